// ===== src/scancode_to_ascii_translator_defines.svh =====
// Assertion macros for the scancode translator.
// Expect clk_i and rst_ni in the scope where they are used.
`ifndef SCANCODE_TO_ASCII_TRANSLATOR_DEFINES_SVH
`define SCANCODE_TO_ASCII_TRANSLATOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SC2A_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("scancode translator: check failed");

// Next-cycle implication, disabled while reset is low.
`define SC2A_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("scancode translator: check failed");

`endif

// ===== src/sc2a_pkg.sv =====
// Shared constants, types and lookup functions for the scancode translator.
// No dependencies.
package sc2a_pkg;

  localparam int unsigned SC2A_MAP_ENTRIES = 58;
  localparam int unsigned SC2A_MAX_RUN     = 4;
  localparam int unsigned SC2A_CHAR_W      = 7;
  localparam int unsigned SC2A_CNT_W       = $clog2(SC2A_MAX_RUN + 1);

  // Scancodes with a special role
  localparam logic [7:0] SC_RELEASE_BIT   = 8'h80;
  localparam logic [7:0] SC_LSHIFT_MAKE   = 8'h2a;
  localparam logic [7:0] SC_LSHIFT_BREAK  = 8'haa;
  localparam logic [7:0] SC_RSHIFT_MAKE   = 8'h36;
  localparam logic [7:0] SC_RSHIFT_BREAK  = 8'hb6;
  localparam logic [7:0] SC_CTRL_MAKE     = 8'h1d;
  localparam logic [7:0] SC_CTRL_BREAK    = 8'h9d;
  localparam logic [7:0] SC_CAPS_MAKE     = 8'h3a;
  localparam logic [7:0] SC_EXT_PREFIX    = 8'he0;
  localparam logic [7:0] SC_UP            = 8'h48;
  localparam logic [7:0] SC_DOWN          = 8'h50;
  localparam logic [7:0] SC_RIGHT         = 8'h4d;
  localparam logic [7:0] SC_LEFT          = 8'h4b;
  localparam logic [7:0] SC_DEL           = 8'h53;
  localparam logic [7:0] SC_HOME          = 8'h47;
  localparam logic [7:0] SC_END           = 8'h4f;

  localparam logic [6:0] CH_ESC   = 7'h1b;
  localparam logic [6:0] CH_LBRK  = 7'h5b;
  localparam logic [6:0] CH_TILDE = 7'h7e;
  localparam logic [6:0] CH_CASE  = 7'h20;

  typedef logic [SC2A_CHAR_W-1:0] char_t;

  typedef struct packed {
    logic [SC2A_CNT_W-1:0]            len;
    logic [SC2A_MAX_RUN-1:0][SC2A_CHAR_W-1:0] bytes;  // bytes[0] goes out first
  } run_t;

  function automatic logic is_letter(input char_t c);
    is_letter = ((c >= 7'h41) && (c <= 7'h5a)) || ((c >= 7'h61) && (c <= 7'h7a));
  endfunction

  // Unshifted keymap; entries that are not defined are zero.
  function automatic char_t map_lower(input logic [6:0] idx);
    case (idx)
      7'd2:  map_lower = 7'h31;  7'd3:  map_lower = 7'h32;  7'd4:  map_lower = 7'h33;
      7'd5:  map_lower = 7'h34;  7'd6:  map_lower = 7'h35;  7'd7:  map_lower = 7'h36;
      7'd8:  map_lower = 7'h37;  7'd9:  map_lower = 7'h38;  7'd10: map_lower = 7'h39;
      7'd11: map_lower = 7'h30;  7'd12: map_lower = 7'h2d;  7'd13: map_lower = 7'h3d;
      7'd14: map_lower = 7'h08;  7'd15: map_lower = 7'h09;  7'd16: map_lower = 7'h71;
      7'd17: map_lower = 7'h77;  7'd18: map_lower = 7'h65;  7'd19: map_lower = 7'h72;
      7'd20: map_lower = 7'h74;  7'd21: map_lower = 7'h79;  7'd22: map_lower = 7'h75;
      7'd23: map_lower = 7'h69;  7'd24: map_lower = 7'h6f;  7'd25: map_lower = 7'h70;
      7'd26: map_lower = 7'h5b;  7'd27: map_lower = 7'h5d;  7'd28: map_lower = 7'h0a;
      7'd30: map_lower = 7'h61;  7'd31: map_lower = 7'h73;  7'd32: map_lower = 7'h64;
      7'd33: map_lower = 7'h66;  7'd34: map_lower = 7'h67;  7'd35: map_lower = 7'h68;
      7'd36: map_lower = 7'h6a;  7'd37: map_lower = 7'h6b;  7'd38: map_lower = 7'h6c;
      7'd39: map_lower = 7'h3b;  7'd40: map_lower = 7'h27;  7'd41: map_lower = 7'h60;
      7'd43: map_lower = 7'h5c;  7'd44: map_lower = 7'h7a;  7'd45: map_lower = 7'h78;
      7'd46: map_lower = 7'h63;  7'd47: map_lower = 7'h76;  7'd48: map_lower = 7'h62;
      7'd49: map_lower = 7'h6e;  7'd50: map_lower = 7'h6d;  7'd51: map_lower = 7'h2c;
      7'd52: map_lower = 7'h2e;  7'd53: map_lower = 7'h2f;  7'd57: map_lower = 7'h20;
      default: map_lower = 7'h00;
    endcase
  endfunction

  // Shifted keymap: symbols differ, letters are the upper case of the plain map.
  function automatic char_t map_shifted(input logic [6:0] idx);
    char_t lo;
    lo = map_lower(idx);
    case (idx)
      7'd2:  map_shifted = 7'h21;  7'd3:  map_shifted = 7'h40;  7'd4:  map_shifted = 7'h23;
      7'd5:  map_shifted = 7'h24;  7'd6:  map_shifted = 7'h25;  7'd7:  map_shifted = 7'h5e;
      7'd8:  map_shifted = 7'h26;  7'd9:  map_shifted = 7'h2a;  7'd10: map_shifted = 7'h28;
      7'd11: map_shifted = 7'h29;  7'd12: map_shifted = 7'h5f;  7'd13: map_shifted = 7'h2b;
      7'd26: map_shifted = 7'h7b;  7'd27: map_shifted = 7'h7d;  7'd39: map_shifted = 7'h3a;
      7'd40: map_shifted = 7'h22;  7'd41: map_shifted = 7'h7e;  7'd43: map_shifted = 7'h7c;
      7'd51: map_shifted = 7'h3c;  7'd52: map_shifted = 7'h3e;  7'd53: map_shifted = 7'h3f;
      default: map_shifted = is_letter(lo) ? (lo ^ CH_CASE) : lo;
    endcase
  endfunction

  // Pick one of the four keymaps; caps lock flips the case of letters only.
  function automatic char_t keymap(input logic [6:0] idx, input logic shift,
                                   input logic caps);
    char_t c;
    c = shift ? map_shifted(idx) : map_lower(idx);
    keymap = (caps && is_letter(c)) ? (c ^ CH_CASE) : c;
  endfunction

  // Fold letters and a few symbols to control codes while ctrl is held.
  function automatic char_t ctrl_fold(input char_t c);
    if (c >= 7'h61 && c <= 7'h7a) begin
      ctrl_fold = c - 7'h60;
    end else if (c >= 7'h41 && c <= 7'h5e) begin
      ctrl_fold = c - 7'h40;
    end else begin
      ctrl_fold = c;
    end
  endfunction

  // Escape sequence for an extended make code; zero length when none.
  function automatic run_t esc_lookup(input logic [7:0] s);
    run_t r;
    r.len   = SC2A_CNT_W'(3);
    r.bytes = '0;
    r.bytes[0] = CH_ESC;
    r.bytes[1] = CH_LBRK;
    case (s)
      SC_UP:    r.bytes[2] = 7'h41;
      SC_DOWN:  r.bytes[2] = 7'h42;
      SC_RIGHT: r.bytes[2] = 7'h43;
      SC_LEFT:  r.bytes[2] = 7'h44;
      SC_DEL: begin
        r.bytes[2] = 7'h33; r.bytes[3] = CH_TILDE; r.len = SC2A_CNT_W'(4);
      end
      SC_HOME: begin
        r.bytes[2] = 7'h31; r.bytes[3] = CH_TILDE; r.len = SC2A_CNT_W'(4);
      end
      SC_END: begin
        r.bytes[2] = 7'h34; r.bytes[3] = CH_TILDE; r.len = SC2A_CNT_W'(4);
      end
      default: r.len = '0;
    endcase
    esc_lookup = r;
  endfunction

endpackage

// ===== src/scancode_to_ascii_translator.sv =====
// Set-1 scancode to ASCII translator, top level.
// Depends on sc2a_pkg and scancode_to_ascii_translator_defines.svh.
//
//   channel  dir  fields (low bit up)                       accept
//   s_*      in   tdata: scan_byte[7:0]                     tvalid & tready
//   m_*      out  tdata: char_out[6:0], pad; tuser:          tvalid & tready
//                 with_ctrl; tlast: last_of_run
//
// A scancode is decoded in the cycle it is taken and its run of 0 to 4 bytes
// lands in the run register, which sends one byte per cycle while m_tready_i is high.
// Plain keys sustain one scancode per cycle while the output is ready; escape
// sequences hold off input while the single-byte output port drains the run register.
// Input is taken while the run register is empty or sends its last byte.
// Reset clears the four key flags and the run count.
`include "scancode_to_ascii_translator_defines.svh"

module scancode_to_ascii_translator
  import sc2a_pkg::*;
#(
  parameter int unsigned MAP_ENTRIES = SC2A_MAP_ENTRIES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       s_tvalid_i,
  output logic       s_tready_o,
  input  logic [7:0] s_tdata_i,   // [7:0] scan_byte
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,   // [6:0] char_out, [7] zero
  output logic       m_tuser_o,   // [0] with_ctrl
  output logic       m_tlast_o
);

  logic                  shift_q, shift_d;
  logic                  caps_q, caps_d;
  logic                  ctrl_q, ctrl_d;
  logic                  prefix_q, prefix_d;
  logic [SC2A_CNT_W-1:0] cnt_q, cnt_d;
  logic [SC2A_MAX_RUN-1:0][SC2A_CHAR_W-1:0] run_q, run_d;
  logic                  wctrl_q, wctrl_d;

  logic   in_fire, out_fire, release_b;
  run_t   new_run;
  run_t   esc_run;
  char_t  key_c;

  assign release_b = |(s_tdata_i & SC_RELEASE_BIT);
  assign esc_run   = esc_lookup(s_tdata_i);

  always_comb begin
    key_c = '0;
    if (!release_b && (s_tdata_i < 8'(MAP_ENTRIES))) begin
      key_c = keymap(s_tdata_i[6:0], shift_q, caps_q);
    end
    if (ctrl_q) begin
      key_c = ctrl_fold(key_c);
    end
  end

  // Decode one scancode: update key flags, build its output run
  always_comb begin
    shift_d  = shift_q;
    caps_d   = caps_q;
    ctrl_d   = ctrl_q;
    prefix_d = prefix_q;
    new_run  = '0;
    if (s_tdata_i == SC_LSHIFT_MAKE || s_tdata_i == SC_LSHIFT_BREAK ||
        s_tdata_i == SC_RSHIFT_MAKE || s_tdata_i == SC_RSHIFT_BREAK) begin
      shift_d = !release_b;
    end else if (s_tdata_i == SC_CTRL_MAKE || s_tdata_i == SC_CTRL_BREAK) begin
      ctrl_d = !release_b;
    end else if (s_tdata_i == SC_CAPS_MAKE) begin
      caps_d = !caps_q;
    end else if (s_tdata_i == SC_EXT_PREFIX) begin
      prefix_d = 1'b1;
    end else if (prefix_q) begin
      prefix_d = 1'b0;
      new_run  = esc_run;
    end else if (key_c != '0) begin
      new_run.len      = SC2A_CNT_W'(1);
      new_run.bytes[0] = key_c;
    end
  end

  assign out_fire   = m_tvalid_o && m_tready_i;
  assign s_tready_o = (cnt_q == '0) || ((cnt_q == SC2A_CNT_W'(1)) && m_tready_i);
  assign in_fire    = s_tvalid_i && s_tready_o;

  always_comb begin
    cnt_d   = cnt_q - SC2A_CNT_W'(out_fire);
    run_d   = run_q;
    wctrl_d = wctrl_q;
    if (out_fire) begin
      run_d = {SC2A_CHAR_W'(0), run_q[SC2A_MAX_RUN-1:1]};
    end
    if (in_fire) begin
      cnt_d = new_run.len;
      if (new_run.len != '0) begin
        run_d   = new_run.bytes;
        wctrl_d = ctrl_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q  <= 1'b0;
      caps_q   <= 1'b0;
      ctrl_q   <= 1'b0;
      prefix_q <= 1'b0;
      cnt_q    <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (in_fire) begin
        shift_q  <= shift_d;
        caps_q   <= caps_d;
        ctrl_q   <= ctrl_d;
        prefix_q <= prefix_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    run_q   <= run_d;
    wctrl_q <= wctrl_d;
  end

  assign m_tvalid_o = (cnt_q != '0);
  assign m_tdata_o  = {1'b0, run_q[0]};
  assign m_tuser_o  = wctrl_q;
  assign m_tlast_o  = (cnt_q == SC2A_CNT_W'(1));

  `SC2A_ASSERT_NOW(a_cnt_bound, 1'b1, cnt_q <= SC2A_CNT_W'(SC2A_MAX_RUN))
  `SC2A_ASSERT_NOW(a_ready_near_empty, s_tready_o, cnt_q <= SC2A_CNT_W'(1))
  `SC2A_ASSERT_NEXT(a_run_continues, out_fire && !m_tlast_o,
                    m_tvalid_o && (m_tuser_o == $past(m_tuser_o)))
  `SC2A_ASSERT_NEXT(a_flags_hold, !in_fire,
                    $stable(shift_q) && $stable(caps_q) && $stable(ctrl_q) && $stable(prefix_q))

endmodule
